// File: src/sqg_pkg.sv
// Shared constants, types and the control store of the SOGI quadrature generator.
package sqg_pkg;

  localparam int SAMPLE_BITS_DEF = 12;
  localparam int DELAY_BITS_DEF  = 48;
  localparam int COEF_BITS       = 32;
  localparam int COEF_FRAC_BITS  = 29;
  localparam int CHUNK_BITS      = 32;
  localparam int OUT_BITS        = 16;
  localparam int CFG_INDEX_BITS  = 3;
  localparam int CFG_DATA_BITS   = 32;
  localparam int STEP_BITS       = 4;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_BANDPASS_GAIN = 3'd0,
    REG_FEEDBACK_ONE  = 3'd1,
    REG_FEEDBACK_TWO  = 3'd2,
    REG_LOWPASS_GAIN  = 3'd3,
    REG_INPUT_OFFSET  = 3'd4
  } cfg_reg_t;

  typedef enum logic [1:0] {COEF_G, COEF_A1, COEF_A2, COEF_H} coef_sel_t;
  typedef enum logic [1:0] {OPND_D1, OPND_D2, OPND_GSUM, OPND_HSUM} opnd_sel_t;
  typedef enum logic {SEC_ALPHA, SEC_BETA} sec_t;
  typedef enum logic [1:0] {OP_NONE, OP_WNODE, OP_OUTA, OP_OUTB} op_t;

  typedef struct packed {
    logic      mul;   // issue a multiply this step
    coef_sel_t coef;
    opnd_sel_t opnd;
    sec_t      sec;
    logic      rpt;   // repeat the step once per operand chunk
    op_t       op;
  } ctrl_t;

  localparam logic [STEP_BITS-1:0] LAST_STEP = 4'd13;

  // Program: feedback node, output and delay update for each section in turn.
  function automatic ctrl_t ucode(input logic [STEP_BITS-1:0] s);
    ctrl_t c;
    c = '{mul: 1'b0, coef: COEF_G, opnd: OPND_D1, sec: SEC_ALPHA, rpt: 1'b0, op: OP_NONE};
    case (s)
      4'd0:  c = '{1'b1, COEF_A1, OPND_D1,   SEC_ALPHA, 1'b1, OP_NONE};
      4'd1:  c = '{1'b1, COEF_A2, OPND_D2,   SEC_ALPHA, 1'b1, OP_NONE};
      4'd2:  c = '{1'b0, COEF_G,  OPND_D1,   SEC_ALPHA, 1'b0, OP_NONE};
      4'd3:  c = '{1'b0, COEF_G,  OPND_D1,   SEC_ALPHA, 1'b0, OP_WNODE};
      4'd4:  c = '{1'b1, COEF_G,  OPND_GSUM, SEC_ALPHA, 1'b1, OP_NONE};
      4'd5:  c = '{1'b0, COEF_G,  OPND_D1,   SEC_ALPHA, 1'b0, OP_NONE};
      4'd6:  c = '{1'b0, COEF_G,  OPND_D1,   SEC_ALPHA, 1'b0, OP_OUTA};
      4'd7:  c = '{1'b1, COEF_A1, OPND_D1,   SEC_BETA,  1'b1, OP_NONE};
      4'd8:  c = '{1'b1, COEF_A2, OPND_D2,   SEC_BETA,  1'b1, OP_NONE};
      4'd9:  c = '{1'b0, COEF_H,  OPND_D1,   SEC_BETA,  1'b0, OP_NONE};
      4'd10: c = '{1'b0, COEF_H,  OPND_D1,   SEC_BETA,  1'b0, OP_WNODE};
      4'd11: c = '{1'b1, COEF_H,  OPND_HSUM, SEC_BETA,  1'b1, OP_NONE};
      4'd12: c = '{1'b0, COEF_H,  OPND_D1,   SEC_BETA,  1'b0, OP_NONE};
      4'd13: c = '{1'b0, COEF_H,  OPND_D1,   SEC_BETA,  1'b0, OP_OUTB};
      default: c = '{1'b0, COEF_G, OPND_D1, SEC_ALPHA, 1'b0, OP_NONE};
    endcase
    return c;
  endfunction

endpackage

// File: src/sqg_if.sv
// Handshake channels of the SOGI quadrature generator: sample, result and configuration.
interface sqg_sample_if import sqg_pkg::*; #(parameter int SAMPLE_BITS = SAMPLE_BITS_DEF) ();
  logic                   valid;
  logic                   ready;
  logic [SAMPLE_BITS-1:0] raw_sample;
  modport source (output valid, output raw_sample, input ready);
  modport sink   (input valid, input raw_sample, output ready);
endinterface

interface sqg_result_if import sqg_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [OUT_BITS-1:0] in_phase;
  logic signed [OUT_BITS-1:0] quadrature;
  modport source (output valid, output in_phase, output quadrature, input ready);
  modport sink   (input valid, input in_phase, input quadrature, output ready);
endinterface

interface sqg_cfg_if import sqg_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic [CFG_INDEX_BITS-1:0] index;
  logic [CFG_DATA_BITS-1:0]  data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// File: src/sogi_quadrature_generator_unit.sv
// SOGI quadrature signal generator: offset removal, band-pass and low-pass sections.
//
// Channels: sample_in carries one unsigned converter sample per beat; result_out carries
// the saturated in-phase and quadrature values for that sample; cfg writes the four
// Q3.29 coefficients and the input offset (index as listed in sqg_pkg, others ignored).
// cfg is always ready; write it only while no sample is in flight.
// One item at a time runs through a microcoded sequencer that drives a single 32 x 33 bit
// multiplier and one accumulator. Each product of a coefficient and a delay-wide operand
// is formed chunk by chunk, NCHUNK = ceil((DELAY_BITS+2)/32) multiplies per product.
// A new sample is taken only once the previous one has finished, which keeps the single
// multiplier shared over the six products; the sample beat is not accepted while busy.
// A finished result sits in the output register while the next sample is accepted;
// if that result has not been taken when the next one finishes, the sequencer holds on
// its last step until result_out.ready.
// Reset (rst, synchronous) clears the four delay registers and the coefficients, sets
// the offset to half scale and drops any pending result.
module sogi_quadrature_generator_unit import sqg_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
  parameter int DELAY_BITS  = DELAY_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  sqg_cfg_if.sink       cfg,
  sqg_sample_if.sink    sample_in,
  sqg_result_if.source  result_out
);

  localparam int DFRAC  = DELAY_BITS - COEF_BITS;
  localparam int OPW    = DELAY_BITS + 2;
  localparam int NCHUNK = (OPW + CHUNK_BITS - 1) / CHUNK_BITS;
  localparam int OPX    = NCHUNK * CHUNK_BITS;
  localparam int CW     = (NCHUNK > 1) ? $clog2(NCHUNK) : 1;
  localparam int ACC_W  = OPX + COEF_BITS + 2;
  localparam int PROD_W = COEF_BITS + CHUNK_BITS + 1;
  localparam int SH     = COEF_FRAC_BITS + DFRAC;
  localparam int DIFF_W = SAMPLE_BITS + 1;
  localparam logic [CW-1:0] LAST_CHUNK = CW'(NCHUNK - 1);

  // configuration
  logic signed [COEF_BITS-1:0] coef_g, coef_a1, coef_a2, coef_h;
  logic [SAMPLE_BITS-1:0]      offset;

  // sequencer and datapath
  logic                         busy;
  logic [STEP_BITS-1:0]         step;
  logic [CW-1:0]                chunk;
  logic signed [DIFF_W-1:0]     diff;
  logic signed [DELAY_BITS-1:0] alpha_d1, alpha_d2, beta_d1, beta_d2, wreg;
  logic signed [PROD_W-1:0]     preg;
  logic [CW-1:0]                pk;
  logic                         pvalid;
  logic signed [ACC_W-1:0]      acc;
  logic signed [OUT_BITS-1:0]   ya;
  logic                         out_valid;
  logic signed [OUT_BITS-1:0]   out_i, out_q;

  ctrl_t                        ctrl;
  logic                         stall;
  logic                         chunk_more;
  logic signed [DELAY_BITS-1:0] d1_sel, d2_sel;
  logic signed [OPW-1:0]        opnd_full;
  logic [OPX-1:0]               opx;
  logic [CHUNK_BITS-1:0]        chunk_bits;
  logic signed [CHUNK_BITS:0]   op33;
  logic signed [COEF_BITS-1:0]  coef_sel;
  logic signed [PROD_W-1:0]     prod;
  logic signed [ACC_W-1:0]      pext, padd;
  logic signed [ACC_W:0]        node_wide;
  logic signed [DELAY_BITS-1:0] w_new;
  logic signed [OUT_BITS-1:0]   y_new;

  function automatic logic signed [DELAY_BITS-1:0] sat_delay(input logic signed [ACC_W:0] v);
    logic [ACC_W-DELAY_BITS+1:0] hi;
    hi = v[ACC_W:DELAY_BITS-1];
    if (&hi || ~|hi) begin
      return v[DELAY_BITS-1:0];
    end else if (v[ACC_W]) begin
      return {1'b1, {(DELAY_BITS-1){1'b0}}};
    end else begin
      return {1'b0, {(DELAY_BITS-1){1'b1}}};
    end
  endfunction

  function automatic logic signed [OUT_BITS-1:0] sat_out(input logic signed [ACC_W-1:0] v);
    logic [ACC_W-OUT_BITS:0] hi;
    hi = v[ACC_W-1:OUT_BITS-1];
    if (&hi || ~|hi) begin
      return v[OUT_BITS-1:0];
    end else if (v[ACC_W-1]) begin
      return {1'b1, {(OUT_BITS-1){1'b0}}};
    end else begin
      return {1'b0, {(OUT_BITS-1){1'b1}}};
    end
  endfunction

  assign ctrl       = ucode(step);
  assign stall      = (ctrl.op == OP_OUTB) && out_valid && !result_out.ready;
  assign chunk_more = ctrl.rpt && (chunk != LAST_CHUNK);

  assign cfg.ready             = 1'b1;
  assign sample_in.ready       = !busy;
  assign result_out.valid      = out_valid;
  assign result_out.in_phase   = out_i;
  assign result_out.quadrature = out_q;

  // operand and coefficient selection
  always_comb begin
    d1_sel = (ctrl.sec == SEC_BETA) ? beta_d1 : alpha_d1;
    d2_sel = (ctrl.sec == SEC_BETA) ? beta_d2 : alpha_d2;
    case (ctrl.opnd)
      OPND_D1:   opnd_full = OPW'(d1_sel);
      OPND_D2:   opnd_full = OPW'(d2_sel);
      OPND_GSUM: opnd_full = OPW'(wreg) - OPW'(d2_sel);
      OPND_HSUM: opnd_full = OPW'(wreg) + (OPW'(d1_sel) <<< 1) + OPW'(d2_sel);
      default:   opnd_full = '0;
    endcase
    case (ctrl.coef)
      COEF_G:  coef_sel = coef_g;
      COEF_A1: coef_sel = coef_a1;
      COEF_A2: coef_sel = coef_a2;
      COEF_H:  coef_sel = coef_h;
      default: coef_sel = '0;
    endcase
  end

  // lower chunks are unsigned, the top chunk carries the sign
  assign opx        = OPX'(opnd_full);
  assign chunk_bits = opx[chunk*CHUNK_BITS +: CHUNK_BITS];
  assign op33       = {(chunk == LAST_CHUNK) & chunk_bits[CHUNK_BITS-1], chunk_bits};
  assign prod       = PROD_W'(coef_sel) * PROD_W'(op33);

  // align the registered partial product to its chunk
  assign pext = ACC_W'(preg);
  always_comb begin
    padd = '0;
    for (int k = 0; k < NCHUNK; k++) begin
      if (pk == CW'(k)) padd = pext << (CHUNK_BITS * k);
    end
  end

  assign node_wide = ((ACC_W + 1)'(diff) <<< DFRAC) - (ACC_W + 1)'(acc >>> COEF_FRAC_BITS);
  assign w_new     = sat_delay(node_wide);
  assign y_new     = sat_out(acc >>> SH);

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      coef_g  <= '0;
      coef_a1 <= '0;
      coef_a2 <= '0;
      coef_h  <= '0;
      offset  <= {1'b1, {(SAMPLE_BITS-1){1'b0}}};
    end else if (cfg.valid) begin
      case (cfg_reg_t'(cfg.index))
        REG_BANDPASS_GAIN: coef_g  <= cfg.data[COEF_BITS-1:0];
        REG_FEEDBACK_ONE:  coef_a1 <= cfg.data[COEF_BITS-1:0];
        REG_FEEDBACK_TWO:  coef_a2 <= cfg.data[COEF_BITS-1:0];
        REG_LOWPASS_GAIN:  coef_h  <= cfg.data[COEF_BITS-1:0];
        REG_INPUT_OFFSET:  offset  <= cfg.data[SAMPLE_BITS-1:0];
        default: ;
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      step  <= '0;
      chunk <= '0;
    end else if (!busy) begin
      if (sample_in.valid) busy <= 1'b1;
    end else if (chunk_more) begin
      chunk <= chunk + CW'(1);
    end else begin
      chunk <= '0;
      if (ctrl.op == OP_OUTB) begin
        if (!stall) begin
          busy <= 1'b0;
          step <= '0;
        end
      end else begin
        step <= step + STEP_BITS'(1);
      end
    end
  end

  // sample capture
  always_ff @(posedge clk) begin
    if (!busy && sample_in.valid) begin
      diff <= $signed({1'b0, sample_in.raw_sample}) - $signed({1'b0, offset});
    end
  end

  // multiplier and accumulator; hold the sum while the last step waits
  always_ff @(posedge clk) begin
    if (rst) begin
      pvalid <= 1'b0;
      acc    <= '0;
    end else begin
      pvalid <= busy && ctrl.mul;
      if (busy && (ctrl.op != OP_NONE) && !stall) begin
        acc <= '0;
      end else if (pvalid) begin
        acc <= acc + padd;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (busy && ctrl.mul) begin
      preg <= prod;
      pk   <= chunk;
    end
  end

  // delay line and results
  always_ff @(posedge clk) begin
    if (rst) begin
      alpha_d1 <= '0;
      alpha_d2 <= '0;
      beta_d1  <= '0;
      beta_d2  <= '0;
    end else if (busy) begin
      if (ctrl.op == OP_OUTA) begin
        alpha_d2 <= alpha_d1;
        alpha_d1 <= wreg;
      end
      if ((ctrl.op == OP_OUTB) && !stall) begin
        beta_d2 <= beta_d1;
        beta_d1 <= wreg;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (busy && (ctrl.op == OP_WNODE)) wreg <= w_new;
    if (busy && (ctrl.op == OP_OUTA)) ya <= y_new;
    if (busy && (ctrl.op == OP_OUTB) && !stall) begin
      out_i <= ya;
      out_q <= y_new;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (busy && (ctrl.op == OP_OUTB) && !stall) begin
      out_valid <= 1'b1;
    end else if (result_out.ready) begin
      out_valid <= 1'b0;
    end
  end

endmodule

// File: tb/tb_sogi_quadrature_generator_unit.sv
// Self-checking testbench for the SOGI quadrature generator, with a bit-exact scoreboard.
`timescale 1ns / 1ps

module tb_sogi_quadrature_generator_unit;
  import sqg_pkg::*;

  localparam int SMP_W    = SAMPLE_BITS_DEF;
  localparam int SMP_MAX  = (1 << SMP_W) - 1;
  localparam int DLY_W    = DELAY_BITS_DEF;
  localparam int DLY_FRAC = DLY_W - 32;
  localparam logic [CFG_INDEX_BITS-1:0] REG_FIRST_UNUSED = 3'd5;
  localparam int CYCLE_LIMIT   = 500000;
  localparam int SETTLE_CYCLES = 40;
  localparam int SETS_PER_LEG  = 4;
  localparam int BEATS_PER_SET = 130;

  // Nominal band-pass/low-pass coefficients: 50 Hz line at 20 kHz, k near sqrt 2
  localparam int LINE_G  = 5880000;
  localparam int LINE_A1 = -1061850000;
  localparam int LINE_A2 = 525110000;
  localparam int LINE_H  = 46180;

  typedef enum int {SET_LINE, SET_LOUD, SET_WILD, SET_EXTREME} coef_set_t;

  typedef struct {
    logic signed [OUT_BITS-1:0] in_phase;
    logic signed [OUT_BITS-1:0] quadrature;
  } iq_pair_t;

  class iq_scoreboard;
    logic signed [COEF_BITS-1:0] gain_g, fb_one, fb_two, gain_h;
    logic [SMP_W-1:0]            offset;
    logic signed [DLY_W-1:0]     bp_d1, bp_d2, lp_d1, lp_d2;
    iq_pair_t                    pending_iq[$];
    int unsigned                 mismatches;

    function new();
      gain_g = '0;
      fb_one = '0;
      fb_two = '0;
      gain_h = '0;
      offset = 12'h800;
      bp_d1 = '0;
      bp_d2 = '0;
      lp_d1 = '0;
      lp_d2 = '0;
      mismatches = 0;
    endfunction

    function void load_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                           input logic [CFG_DATA_BITS-1:0] val);
      case (idx)
        REG_BANDPASS_GAIN: gain_g = val;
        REG_FEEDBACK_ONE:  fb_one = val;
        REG_FEEDBACK_TWO:  fb_two = val;
        REG_LOWPASS_GAIN:  gain_h = val;
        REG_INPUT_OFFSET:  offset = val[SMP_W-1:0];
        default: ;
      endcase
    endfunction

    function logic signed [127:0] saturate(input logic signed [127:0] x, input int bits);
      logic signed [127:0] lim;
      lim = 128'sd1 <<< (bits - 1);
      if (x >= lim) return lim - 1;
      if (x < -lim) return -lim;
      return x;
    endfunction

    // New delay value of one section: input less the shared feedback, clamped to delay width
    function logic signed [127:0] section_w(input logic signed [127:0] u, d1, d2);
      logic signed [127:0] a1, a2;
      a1 = fb_one;
      a2 = fb_two;
      return saturate(u - ((a1 * d1 + a2 * d2) >>> COEF_FRAC_BITS), DLY_W);
    endfunction

    function iq_pair_t next_iq_pair(input logic [SMP_W-1:0] raw);
      logic signed [127:0] s, o, u, wa, wb, g, h, y;
      iq_pair_t r;
      s = raw;
      o = offset;
      u = (s - o) <<< DLY_FRAC;
      g = gain_g;
      h = gain_h;

      wa = section_w(u, bp_d1, bp_d2);
      y = saturate((g * wa - g * bp_d2) >>> (COEF_FRAC_BITS + DLY_FRAC), OUT_BITS);
      r.in_phase = y[OUT_BITS-1:0];
      bp_d2 = bp_d1;
      bp_d1 = wa[DLY_W-1:0];

      wb = section_w(u, lp_d1, lp_d2);
      y = saturate((h * wb + 2 * h * lp_d1 + h * lp_d2) >>> (COEF_FRAC_BITS + DLY_FRAC),
                   OUT_BITS);
      r.quadrature = y[OUT_BITS-1:0];
      lp_d2 = lp_d1;
      lp_d1 = wb[DLY_W-1:0];
      return r;
    endfunction

    function void take_sample(input logic [SMP_W-1:0] raw);
      pending_iq.push_back(next_iq_pair(raw));
    endfunction

    function void check_result(input logic signed [OUT_BITS-1:0] ip, q);
      iq_pair_t e;
      if (pending_iq.size() == 0) begin
        $display("%0t: unexpected result, expected none, got in_phase %0d quadrature %0d",
                 $time, ip, q);
        mismatches++;
        return;
      end
      e = pending_iq.pop_front();
      if (ip !== e.in_phase) begin
        $display("%0t: in_phase mismatch, expected %0d, got %0d", $time, e.in_phase, ip);
        mismatches++;
      end
      if (q !== e.quadrature) begin
        $display("%0t: quadrature mismatch, expected %0d, got %0d", $time, e.quadrature, q);
        mismatches++;
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  int   send_idle;
  int   recv_idle;
  int   cycles;
  iq_scoreboard sb;

  sqg_cfg_if    cfg_ch ();
  sqg_sample_if sample_ch ();
  sqg_result_if result_ch ();

  sogi_quadrature_generator_unit DUT (
    .clk,
    .rst,
    .cfg        (cfg_ch),
    .sample_in  (sample_ch),
    .result_out (result_ch)
  );

  initial clk = 1'b0;
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  initial begin
    result_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      result_ch.ready <= ($urandom_range(99) >= recv_idle);
    end
  end

  always @(posedge clk) begin
    if (!rst && result_ch.valid && result_ch.ready)
      sb.check_result(result_ch.in_phase, result_ch.quadrature);
  end

  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("Some tests failed");
    $finish;
  end

  // Leaves valid high; the caller drops it after the last beat of a burst
  task automatic drive_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                           input logic [CFG_DATA_BITS-1:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    sb.load_reg(idx, val);
    @(negedge clk);
  endtask

  task automatic drive_sample(input logic [SMP_W-1:0] s);
    while ($urandom_range(99) < send_idle) begin
      sample_ch.valid <= 1'b0;
      @(negedge clk);
    end
    sample_ch.valid      <= 1'b1;
    sample_ch.raw_sample <= s;
    @(posedge clk);
    while (!sample_ch.ready) @(posedge clk);
    sb.take_sample(s);
    @(negedge clk);
  endtask

  // Hold until every result is out, then let the sequencer settle
  task automatic wait_drained();
    while (sb.pending_iq.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  function automatic logic [31:0] extreme_coef();
    case ($urandom_range(4))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'h0000_0000;
      3: return 32'h0000_0001;
      default: return 32'hFFFF_FFFF;
    endcase
  endfunction

  task automatic configure(input coef_set_t profile);
    int g, a1, a2, h;
    logic [SMP_W-1:0] off;
    case (profile)
      SET_LINE: begin
        g   = LINE_G + int'($urandom_range(1000000)) - 500000;
        a1  = LINE_A1 + int'($urandom_range(100000)) - 50000;
        a2  = LINE_A2 + int'($urandom_range(100000)) - 50000;
        h   = LINE_H + int'($urandom_range(40000)) - 20000;
        off = SMP_W'(1948 + $urandom_range(200));
      end
      SET_LOUD: begin
        // stable poles, gains large enough to drive both outputs into saturation
        g   = $urandom | 32'h1000_0000;
        a1  = LINE_A1;
        a2  = LINE_A2;
        h   = $urandom | 32'h0800_0000;
        off = SMP_W'($urandom);
      end
      SET_WILD: begin
        g   = $urandom;
        a1  = $urandom;
        a2  = $urandom;
        h   = $urandom;
        off = SMP_W'($urandom);
      end
      default: begin
        g  = extreme_coef();
        a1 = extreme_coef();
        a2 = extreme_coef();
        h  = extreme_coef();
        case ($urandom_range(2))
          0: off = '0;
          1: off = SMP_W'(SMP_MAX);
          default: off = 12'h800;
        endcase
      end
    endcase
    drive_reg(REG_BANDPASS_GAIN, g);
    drive_reg(REG_FEEDBACK_ONE, a1);
    drive_reg(REG_FEEDBACK_TWO, a2);
    drive_reg(REG_LOWPASS_GAIN, h);
    // upper data bits must be dropped by the offset register
    drive_reg(REG_INPUT_OFFSET, {20'($urandom), off});
    drive_reg(CFG_INDEX_BITS'($urandom_range(2**CFG_INDEX_BITS - 1, REG_FIRST_UNUSED)),
              $urandom);
    cfg_ch.valid <= 1'b0;
  endtask

  // Mostly a noisy line sine around mid-scale, with uniform samples mixed in
  task automatic stream_samples(input int count);
    real ph, step, amp, centre, v;
    int n;
    logic [SMP_W-1:0] s;
    ph     = 0.0;
    step   = 0.0157 * (0.5 + real'($urandom_range(100)) / 100.0);
    amp    = real'($urandom_range(2200));
    centre = 2048.0 + real'($urandom_range(400)) - 200.0;
    for (n = 0; n < count; n++) begin
      if ($urandom_range(3) == 0) begin
        s = SMP_W'($urandom_range(SMP_MAX));
      end else begin
        v = centre + amp * $sin(ph) + real'($urandom_range(64)) - 32.0;
        if (v < 0.0) v = 0.0;
        if (v > real'(SMP_MAX)) v = real'(SMP_MAX);
        s = SMP_W'($rtoi(v));
      end
      ph = ph + step;
      drive_sample(s);
    end
    sample_ch.valid <= 1'b0;
  endtask

  initial begin
    int leg, k;
    sb = new();
    rst = 1'b1;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = REG_BANDPASS_GAIN;
    cfg_ch.data = '0;
    sample_ch.valid = 1'b0;
    sample_ch.raw_sample = '0;
    send_idle = 0;
    recv_idle = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // coefficients still at reset: both outputs stay zero while the delays fill
    drive_sample('0);
    drive_sample(SMP_W'(SMP_MAX));
    drive_sample(12'h800);
    drive_sample(12'hAAA);
    drive_sample(12'h555);
    sample_ch.valid <= 1'b0;
    wait_drained();

    // extreme coefficients: delay and output saturation
    drive_reg(REG_BANDPASS_GAIN, 32'h7FFF_FFFF);
    drive_reg(REG_FEEDBACK_ONE, 32'h8000_0000);
    drive_reg(REG_FEEDBACK_TWO, 32'h7FFF_FFFF);
    drive_reg(REG_LOWPASS_GAIN, 32'h8000_0000);
    drive_reg(REG_INPUT_OFFSET, 32'hFFFF_F000);
    drive_reg(REG_FIRST_UNUSED, 32'h7FFF_FFFF);
    cfg_ch.valid <= 1'b0;
    repeat (4) drive_sample(SMP_W'(SMP_MAX));
    repeat (3) drive_sample('0);
    sample_ch.valid <= 1'b0;
    wait_drained();

    drive_reg(REG_BANDPASS_GAIN, 32'h8000_0000);
    drive_reg(REG_FEEDBACK_ONE, 32'h7FFF_FFFF);
    drive_reg(REG_FEEDBACK_TWO, 32'h8000_0000);
    drive_reg(REG_LOWPASS_GAIN, 32'h7FFF_FFFF);
    drive_reg(REG_INPUT_OFFSET, 32'h0000_0FFF);
    drive_reg('1, 32'h0000_0000);
    cfg_ch.valid <= 1'b0;
    repeat (4) drive_sample('0);
    repeat (3) drive_sample(SMP_W'(SMP_MAX));
    sample_ch.valid <= 1'b0;

    for (leg = 0; leg < 3; leg++) begin
      case (leg)
        0: begin
          send_idle = 22;
          recv_idle = 55;
        end
        1: begin
          send_idle = 55;
          recv_idle = 22;
        end
        default: begin
          send_idle = 0;
          recv_idle = 0;
        end
      endcase
      for (k = 0; k < SETS_PER_LEG; k++) begin
        wait_drained();
        configure(coef_set_t'(k));
        stream_samples(BEATS_PER_SET);
      end
    end

    wait_drained();
    if (sb.mismatches == 0 && sb.pending_iq.size() == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule
